// ===== rtl/sawalk_pkg.sv =====
// Shared types, codes and helper functions for the self-avoiding walk stepper.
// Used by sawalk_pick, the top level and the scoreboard; depends on nothing else.
`default_nettype none

package sawalk_pkg;

    typedef enum logic [2:0] {
        ST_STARTED  = 3'd0,
        ST_MOVED    = 3'd1,
        ST_TRAPPED  = 3'd2,
        ST_ESCAPED  = 3'd3,
        ST_FINISHED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DIR_YP = 2'd0,
        DIR_XP = 2'd1,
        DIR_YN = 2'd2,
        DIR_XN = 2'd3
    } dir_t;

    typedef struct packed {
        logic any_free;
        dir_t dir;
    } pick_t;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // An 8-bit value modulo three: base-4 digits sum to the same residue.
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        if (s >= 4'd6)
        begin
            s = s - 4'd6;
        end
        if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        return s[1:0];
    endfunction

    function automatic logic at_boundary(input logic signed [7:0] x,
                                         input logic signed [7:0] y,
                                         input logic [6:0] b);
        logic [7:0] ax;
        logic [7:0] ay;
        ax = x[7] ? 8'(-x) : 8'(x);
        ay = y[7] ? 8'(-y) : 8'(y);
        return (ax >= {1'b0, b}) || (ay >= {1'b0, b});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sawalk_map_ram.sv =====
// Visited-site bitmap: one row of the lattice per word, one read and one write port.
// Read data is registered; no package dependency.
`default_nettype none

module sawalk_map_ram #(
    parameter int GRID_SIDE = 256
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(GRID_SIDE)-1:0] wr_addr,
    input  wire logic [GRID_SIDE-1:0]         wr_data,
    input  wire logic [$clog2(GRID_SIDE)-1:0] rd_addr,
    output logic      [GRID_SIDE-1:0]         rd_data
);

    logic [GRID_SIDE-1:0] mem [GRID_SIDE];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/sawalk_pick.sv =====
// Chooses the free neighbour numbered random mod free count, in +y, +x, -y, -x order.
// Depends on sawalk_pkg.
`default_nettype none

module sawalk_pick (
    input  wire logic [3:0]          free_dirs,
    input  wire logic [7:0]          rnd,
    output sawalk_pkg::pick_t        pick
);

    import sawalk_pkg::*;

    logic [2:0] free_count;
    logic [1:0] pick_idx;

    always_comb
    begin
        free_count = 3'($countones(free_dirs));
        case (free_count)
            3'd2:    pick_idx = {1'b0, rnd[0]};
            3'd3:    pick_idx = mod3(rnd);
            3'd4:    pick_idx = rnd[1:0];
            default: pick_idx = 2'd0;
        endcase
    end

    always_comb
    begin
        logic [1:0] seen;
        logic       found;
        seen     = 2'd0;
        found    = 1'b0;
        pick.dir = DIR_YP;
        for (int d = 0; d < 4; d++)
        begin
            if (free_dirs[d] && !found)
            begin
                if (seen == pick_idx)
                begin
                    found    = 1'b1;
                    pick.dir = dir_t'(2'(d));
                end
                seen = seen + 2'd1;
            end
        end
        pick.any_free = (free_count != 3'd0);
    end

endmodule

`default_nettype wire

// ===== rtl/self_avoiding_walk_stepper_unit.sv =====
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       tdata: random_bits; tuser: command
// m_        out  m_tvalid / m_tready       tdata: pos_x, pos_y, visited_count; tuser: status
// cfg_      in   cfg_wr_en (no wait)       cfg_wr_data: boundary
//
// A step makes three row reads of the bitmap memory (one read port) and one
// read-modify-write of the chosen row. A start sweeps all GRID_SIDE rows of the memory,
// one row a cycle. A step with no walk running, or from a boundary site, reads no rows and
// goes straight to the output state. A finished word waits in the output register while
// the next word is taken; the last state of a step holds while that register is full and not drained.
// Reset clears control state; the bitmap is cleared only by a start.
//
// Top level of the self-avoiding walk stepper.
// Depends on sawalk_pkg, sawalk_map_ram and sawalk_pick.
`default_nettype none

module self_avoiding_walk_stepper_unit #(
    parameter int GRID_SIDE = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] random_bits
    input  wire logic        s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [7:0] pos_x, [15:8] pos_y, [32:16] visited_count
    output logic      [2:0]  m_tuser,   // [2:0] status
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data
);

    import sawalk_pkg::*;

    localparam int IW = $clog2(GRID_SIDE);
    localparam logic [IW-1:0] IDX_LAST = IW'(GRID_SIDE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_RDP,
        S_RDX,
        S_RDM,
        S_WR,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [6:0]             boundary_reg;
    logic signed [7:0]      x_reg;
    logic signed [7:0]      y_reg;
    logic [IW-1:0]          row_reg;
    logic [IW-1:0]          col_reg;
    logic                   active_reg;
    logic [16:0]            count_reg;
    logic [16:0]            count_next;
    status_t                status_reg;
    logic [7:0]             rnd_reg;
    logic                   vis_yp_reg;
    logic                   vis_yn_reg;
    logic                   vis_xp_reg;
    logic [IW-1:0]          clr_reg;
    logic                   m_tvalid_reg;
    logic [39:0]            m_tdata_reg;
    status_t                m_tuser_reg;

    logic [IW-1:0]          row_up;
    logic [IW-1:0]          row_dn;
    logic [IW-1:0]          col_up;
    logic [IW-1:0]          col_dn;
    logic                   out_free;
    logic                   out_load;
    logic                   accept;
    logic                   new_at_bnd;
    pick_t                  pick;
    logic [3:0]             free_dirs;

    logic                   ram_wr_en;
    logic [IW-1:0]          ram_wr_addr;
    logic [GRID_SIDE-1:0]   ram_wr_data;
    logic [IW-1:0]          ram_rd_addr;
    logic [GRID_SIDE-1:0]   ram_rd_data;

    assign row_up   = (row_reg == IDX_LAST) ? '0 : row_reg + IW'(1);
    assign row_dn   = (row_reg == '0) ? IDX_LAST : row_reg - IW'(1);
    assign col_up   = (col_reg == IDX_LAST) ? '0 : col_reg + IW'(1);
    assign col_dn   = (col_reg == '0) ? IDX_LAST : col_reg - IW'(1);

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = ((state_reg == S_WR) || (state_reg == S_OUT)) && out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign count_next = (count_reg < COUNT_MAX) ? count_reg + 17'd1 : count_reg;
    assign new_at_bnd = at_boundary(x_reg, y_reg, boundary_reg);

    assign free_dirs = {!ram_rd_data[col_reg], !vis_yn_reg, !vis_xp_reg, !vis_yp_reg};

    sawalk_pick u_pick (
        .free_dirs (free_dirs),
        .rnd       (rnd_reg),
        .pick      (pick)
    );

    always_comb
    begin
        case (state_reg)
            S_RDP:   ram_rd_addr = row_up;
            S_RDX:   ram_rd_addr = row_dn;
            S_RDM:
            begin
                case (pick.dir)
                    DIR_XP:  ram_rd_addr = row_up;
                    DIR_XN:  ram_rd_addr = row_dn;
                    default: ram_rd_addr = row_reg;
                endcase
            end
            default: ram_rd_addr = row_reg;
        endcase
    end

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = row_reg;
        ram_wr_data = ram_rd_data | (GRID_SIDE'(1) << col_reg);
        if (state_reg == S_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_reg;
            ram_wr_data = (clr_reg == '0) ? GRID_SIDE'(3) : '0;
        end
        else if (state_reg == S_WR)
        begin
            ram_wr_en = out_free;
        end
    end

    sawalk_map_ram #(
        .GRID_SIDE (GRID_SIDE)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            boundary_reg <= 7'd127;
            x_reg        <= 8'sd0;
            y_reg        <= 8'sd1;
            row_reg      <= '0;
            col_reg      <= IW'(1);
            active_reg   <= 1'b0;
            count_reg    <= '0;
            status_reg   <= ST_FINISHED;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                boundary_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rnd_reg <= s_tdata;
                        if (s_tuser == CMD_START)
                        begin
                            clr_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end
                        else if (!active_reg)
                        begin
                            status_reg <= ST_FINISHED;
                            state_reg  <= S_OUT;
                        end
                        else if (at_boundary(x_reg, y_reg, boundary_reg))
                        begin
                            active_reg <= 1'b0;
                            status_reg <= ST_ESCAPED;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RDP;
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + IW'(1);
                    if (clr_reg == IDX_LAST)
                    begin
                        x_reg      <= 8'sd0;
                        y_reg      <= 8'sd1;
                        row_reg    <= '0;
                        col_reg    <= IW'(1);
                        count_reg  <= 17'd2;
                        active_reg <= 1'b1;
                        status_reg <= ST_STARTED;
                        state_reg  <= S_OUT;
                    end
                end
                S_RDP:
                begin
                    vis_yp_reg <= ram_rd_data[col_up];
                    vis_yn_reg <= ram_rd_data[col_dn];
                    state_reg  <= S_RDX;
                end
                S_RDX:
                begin
                    vis_xp_reg <= ram_rd_data[col_reg];
                    state_reg  <= S_RDM;
                end
                S_RDM:
                begin
                    if (!pick.any_free)
                    begin
                        active_reg <= 1'b0;
                        status_reg <= ST_TRAPPED;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        case (pick.dir)
                            DIR_YP:
                            begin
                                y_reg   <= y_reg + 8'sd1;
                                col_reg <= col_up;
                            end
                            DIR_XP:
                            begin
                                x_reg   <= x_reg + 8'sd1;
                                row_reg <= row_up;
                            end
                            DIR_YN:
                            begin
                                y_reg   <= y_reg - 8'sd1;
                                col_reg <= col_dn;
                            end
                            default:
                            begin
                                x_reg   <= x_reg - 8'sd1;
                                row_reg <= row_dn;
                            end
                        endcase
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    if (out_free)
                    begin
                        count_reg    <= count_next;
                        if (new_at_bnd)
                        begin
                            active_reg <= 1'b0;
                        end
                        m_tdata_reg  <= {7'd0, count_next, y_reg, x_reg};
                        m_tuser_reg  <= new_at_bnd ? ST_ESCAPED : ST_MOVED;
                        state_reg    <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {7'd0, count_reg, y_reg, x_reg};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_write_free_site: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && ram_wr_en) |-> !ram_rd_data[col_reg])
        else $error("Walker stepped onto a site already marked visited.");

    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (count_reg >= 17'd2))
        else $error("Running walk has fewer than two visited sites.");

    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDP) |-> $past(accept))
        else $error("Neighbour reads started without an accepted step.");
`endif

endmodule

`default_nettype wire

// ===== dv/sawalk_step_check.sv =====
// Scoreboard for the self-avoiding walk stepper: mirrors the walk on every accepted word
// and compares each output word with the oldest prediction. Depends on sawalk_pkg.
`timescale 1ns / 100ps

module sawalk_step_check #(
    parameter int GRID_SIDE = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    output int               fail_count,
    output int               pending_words,
    output logic             walk_live
);

    import sawalk_pkg::*;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        status_t     status;
        logic [16:0] count;
    } walk_word_t;

    bit          seen [GRID_SIDE * GRID_SIDE];
    int          wx;
    int          wy;
    logic [16:0] sites;
    logic [6:0]  bound_reg;
    walk_word_t  word_q [$];

    function automatic int site_of(input int x, input int y);
        int xm;
        int ym;
        xm = ((x % GRID_SIDE) + GRID_SIDE) % GRID_SIDE;
        ym = ((y % GRID_SIDE) + GRID_SIDE) % GRID_SIDE;
        return xm * GRID_SIDE + ym;
    endfunction

    function automatic bit beyond(input int x, input int y, input logic [6:0] b);
        int ax;
        int ay;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        return (ax >= int'(b)) || (ay >= int'(b));
    endfunction

    // Neighbors are searched in the order +y, +x, -y, -x.
    task automatic take_step(input logic cmd, input logic [7:0] rnd, output walk_word_t w);
        int      dx [4];
        int      dy [4];
        bit      open [4];
        int      n_open;
        int      pick;
        int      dir;
        int      d;
        status_t st;
        dx = '{0, 1, 0, -1};
        dy = '{1, 0, -1, 0};
        if (cmd == CMD_START)
        begin
            foreach (seen[k])
            begin
                seen[k] = 1'b0;
            end
            seen[site_of(0, 0)] = 1'b1;
            seen[site_of(0, 1)] = 1'b1;
            wx = 0;
            wy = 1;
            sites = 17'd2;
            walk_live = 1'b1;
            st = ST_STARTED;
        end
        else if (!walk_live)
        begin
            st = ST_FINISHED;
        end
        else if (beyond(wx, wy, bound_reg))
        begin
            walk_live = 1'b0;
            st = ST_ESCAPED;
        end
        else
        begin
            n_open = 0;
            for (d = 0; d < 4; d++)
            begin
                open[d] = !seen[site_of(wx + dx[d], wy + dy[d])];
                if (open[d])
                begin
                    n_open++;
                end
            end
            if (n_open == 0)
            begin
                walk_live = 1'b0;
                st = ST_TRAPPED;
            end
            else
            begin
                pick = int'(rnd) % n_open;
                dir = -1;
                for (d = 0; d < 4; d++)
                begin
                    if (open[d] && dir < 0)
                    begin
                        if (pick == 0)
                        begin
                            dir = d;
                        end
                        else
                        begin
                            pick--;
                        end
                    end
                end
                wx += dx[dir];
                wy += dy[dir];
                seen[site_of(wx, wy)] = 1'b1;
                if (sites != COUNT_MAX)
                begin
                    sites++;
                end
                if (beyond(wx, wy, bound_reg))
                begin
                    walk_live = 1'b0;
                    st = ST_ESCAPED;
                end
                else
                begin
                    st = ST_MOVED;
                end
            end
        end
        w.x = 8'(wx);
        w.y = 8'(wy);
        w.status = st;
        w.count = sites;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        walk_word_t want;
        walk_word_t got;
        if (!rst_n)
        begin
            foreach (seen[k])
            begin
                seen[k] = 1'b0;
            end
            wx = 0;
            wy = 1;
            sites = '0;
            walk_live = 1'b0;
            bound_reg = 7'd127;
            word_q.delete();
            fail_count = 0;
            pending_words = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bound_reg = cfg_wr_data;
            end
            if (s_tvalid && s_tready)
            begin
                take_step(s_tuser, s_tdata, want);
                word_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.x = m_tdata[7:0];
                got.y = m_tdata[15:8];
                got.count = m_tdata[32:16];
                got.status = status_t'(m_tuser);
                if (word_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: output word with nothing expected, status=%0d",
                                 $time, m_tuser);
                    end
                    fail_count++;
                end
                else
                begin
                    want = word_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                        begin
                            $display({"%0t: word mismatch, expected x=%0d y=%0d status=%0d",
                                      " count=%0d, got x=%0d y=%0d status=%0d count=%0d"},
                                     $time, $signed(want.x), $signed(want.y), want.status,
                                     want.count, $signed(got.x), $signed(got.y), m_tuser,
                                     got.count);
                        end
                        fail_count++;
                    end
                end
            end
            pending_words = word_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the walk stepper testbench: clock, reset, boundary settings and command words.
// Depends on sawalk_pkg, self_avoiding_walk_stepper_unit and sawalk_step_check.
`timescale 1ns / 100ps

module testbench;

    import sawalk_pkg::*;

    localparam int GRID_SIDE = 256;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    int          fail_count;
    int          pending_words;
    logic        walk_live;
    int          tx_idle_pct = 26;
    int          rx_idle_pct = 53;
    logic [6:0]  phase_bound [6];

    self_avoiding_walk_stepper_unit #(
        .GRID_SIDE(GRID_SIDE)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    sawalk_step_check #(
        .GRID_SIDE(GRID_SIDE)
    ) i_step_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count),
        .pending_words(pending_words),
        .walk_live(walk_live)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                tx_idle_pct = 26;
                rx_idle_pct = 53;
            end
            1:
            begin
                tx_idle_pct = 53;
                rx_idle_pct = 26;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    // The ready line only changes at the rising edge, so it is checked at the falling edge
    // and the word is taken at the rising edge that follows.
    task automatic send_word(input logic cmd, input logic [7:0] rnd);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= rnd;
        while (!s_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic write_bound(input logic [6:0] b);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= b;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int   ph;
        int   i;
        logic cmd;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_STEP;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        phase_bound = '{7'd127, 7'd3, 7'd127, 7'd6, 7'd40, 7'd2};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idle(0);
        // Steps before any walk, then two starts in a row and a short walk.
        send_word(CMD_STEP, 8'd0);
        send_word(CMD_STEP, 8'd255);
        send_word(CMD_START, 8'd255);
        send_word(CMD_START, 8'd0);
        send_word(CMD_STEP, 8'd0);
        send_word(CMD_STEP, 8'd1);
        send_word(CMD_STEP, 8'd2);
        send_word(CMD_STEP, 8'd3);
        send_word(CMD_STEP, 8'd255);
        send_word(CMD_STEP, 8'd128);
        send_word(CMD_STEP, 8'd85);
        send_word(CMD_STEP, 8'd170);
        // The walker is left outside a lowered boundary and must stop in place.
        wait_idle();
        write_bound(7'd1);
        send_word(CMD_STEP, 8'd7);
        send_word(CMD_STEP, 8'd7);
        wait_idle();
        write_bound(7'd0);
        send_word(CMD_START, 8'd19);
        send_word(CMD_STEP, 8'd0);
        wait_idle();
        write_bound(7'd2);
        send_word(CMD_START, 8'd200);
        send_word(CMD_STEP, 8'd0);
        send_word(CMD_STEP, 8'd64);

        for (ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            write_bound(phase_bound[ph]);
            set_idle(ph / 2);
            for (i = 0; i < 200; i++)
            begin
                if (walk_live)
                begin
                    cmd = ($urandom_range(0, 99) < 1) ? CMD_START : CMD_STEP;
                end
                else
                begin
                    cmd = ($urandom_range(0, 99) < 85) ? CMD_START : CMD_STEP;
                end
                send_word(cmd, 8'($urandom_range(0, 255)));
            end
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_words != 0)
        begin
            @(negedge clk);
        end
        repeat (GRID_SIDE + 8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench failed");
        $finish;
    end

endmodule
